FILE: rtl/core/vspc_pkg.sv
// Shared types and constants for the vehicle start and pedal check unit.
// No dependencies; imported by every module of the block.
package vspc_pkg;

    // Vehicle modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SHOLD  = 2'd1;
    localparam logic [1:0] MODE_BUZZER = 2'd2;
    localparam logic [1:0] MODE_DRIVE  = 2'd3;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_BRAKE_THR  = 3'd0;
    localparam logic [2:0] REG_START_HOLD = 3'd1;
    localparam logic [2:0] REG_BUZZER     = 3'd2;
    localparam logic [2:0] REG_MISMATCH   = 3'd3;
    localparam logic [2:0] REG_FORWARD    = 3'd4;
    localparam logic [2:0] REG_TOLERANCE  = 3'd5;

    // Field widths
    localparam int ADC_W      = 10;
    localparam int CFG_TIMER_W = 16;
    localparam int TOL_W      = 7;
    localparam int SCALED_W   = 11;
    localparam int TORQUE_W   = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    // aux * 50 / 33 as a multiply by ceil(2^22 / 33) * 50, then shift by 22
    localparam int          AUX_SHIFT = 22;
    localparam logic [22:0] AUX_MULT  = 23'd6355050;

    typedef struct packed {
        logic [ADC_W-1:0]       brake_limit;
        logic [CFG_TIMER_W-1:0] start_hold_ticks;
        logic [CFG_TIMER_W-1:0] buzzer_ticks;
        logic [CFG_TIMER_W-1:0] mismatch_ticks;
        logic                   forward_direction;
        logic [TOL_W-1:0]       tolerance_percent;
    } t_cfg;

    // Contents of the input register
    typedef struct packed {
        logic                start_button;
        logic [ADC_W-1:0]    brake_level;
        logic [ADC_W-1:0]    pedal_main;
        logic [SCALED_W-1:0] scaled_aux;
        logic [TORQUE_W-1:0] torque_word;
    } t_stage;

    // One result beat
    typedef struct packed {
        logic [1:0]                 vehicle_state;
        logic                       brake_light;
        logic                       buzzer_on;
        logic signed [TORQUE_W-1:0] torque_command;
        logic                       torque_valid;
        logic                       mismatch_pending;
    } t_result;

endpackage

FILE: rtl/core/vspc_regs.sv
// APB configuration registers of the vehicle start and pedal check unit.
// Depends on vspc_pkg for the register indexes and the t_cfg type.
module vspc_regs import vspc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brake_limit       <= 10'd200;
            r_cfg.start_hold_ticks  <= 16'd2000;
            r_cfg.buzzer_ticks      <= 16'd2000;
            r_cfg.mismatch_ticks    <= 16'd100;
            r_cfg.forward_direction <= 1'b1;
            r_cfg.tolerance_percent <= 7'd10;
        end else if (wr_en) begin
            unique case (idx)
                REG_BRAKE_THR:  r_cfg.brake_limit       <= pwdata[ADC_W-1:0];
                REG_START_HOLD: r_cfg.start_hold_ticks  <= pwdata[CFG_TIMER_W-1:0];
                REG_BUZZER:     r_cfg.buzzer_ticks      <= pwdata[CFG_TIMER_W-1:0];
                REG_MISMATCH:   r_cfg.mismatch_ticks    <= pwdata[CFG_TIMER_W-1:0];
                REG_FORWARD:    r_cfg.forward_direction <= pwdata[0];
                REG_TOLERANCE:  r_cfg.tolerance_percent <= pwdata[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_BRAKE_THR:  prdata = 32'(r_cfg.brake_limit);
            REG_START_HOLD: prdata = 32'(r_cfg.start_hold_ticks);
            REG_BUZZER:     prdata = 32'(r_cfg.buzzer_ticks);
            REG_MISMATCH:   prdata = 32'(r_cfg.mismatch_ticks);
            REG_FORWARD:    prdata = 32'(r_cfg.forward_direction);
            REG_TOLERANCE:  prdata = 32'(r_cfg.tolerance_percent);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/vspc_prep.sv
// Input register of the pedal check: scales the aux reading and forms the torque word.
// Depends on vspc_pkg for t_cfg, t_stage and the scaling constants.
module vspc_prep import vspc_pkg::*; #(
    parameter int ADC_MAX = 1023
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  t_cfg             i_cfg,
    input  logic             i_start_button,
    input  logic [ADC_W-1:0] i_brake_level,
    input  logic [ADC_W-1:0] i_pedal_main,
    input  logic [ADC_W-1:0] i_pedal_aux,
    output t_stage           o_stage
);

    // x * C / ADC_MAX as x * ceil(C * 2^K / ADC_MAX) >> K; exact for x below 2^10
    localparam int          TQ_SHIFT = 26;
    localparam logic [63:0] MULT_FWD =
        ((64'd32767 << TQ_SHIFT) + 64'(ADC_MAX) - 64'd1) / 64'(ADC_MAX);
    localparam logic [63:0] MULT_REV =
        ((64'd32768 << TQ_SHIFT) + 64'(ADC_MAX) - 64'd1) / 64'(ADC_MAX);
    localparam int MW   = $clog2(MULT_REV + 64'd1);
    // product stays below 2^(K+16) since x never exceeds ADC_MAX
    localparam int PW   = TQ_SHIFT + TORQUE_W;
    localparam int QW   = TORQUE_W;

    t_stage             r_stage;
    logic [ADC_W-1:0]   x_clamped;
    logic [MW-1:0]      mult;
    logic [PW-1:0]      tq_prod;
    logic [QW-1:0]      tq_mag;
    logic [TORQUE_W-1:0] tq_word;
    logic [32:0]        aux_prod;

    // Clamp the main reading to full scale
    assign x_clamped = (17'(i_pedal_main) > 17'(ADC_MAX)) ? ADC_W'(ADC_MAX) : i_pedal_main;

    // Torque magnitude and sign
    assign mult    = i_cfg.forward_direction ? MW'(MULT_FWD) : MW'(MULT_REV);
    assign tq_prod = PW'(x_clamped) * PW'(mult);
    assign tq_mag  = tq_prod[TQ_SHIFT +: QW];
    always_comb begin
        if (i_cfg.forward_direction) begin
            tq_word = tq_mag[TORQUE_W-1:0];
        end else begin
            tq_word = TORQUE_W'(-tq_mag);
        end
    end

    // aux * 50 / 33, floored
    assign aux_prod = 33'(i_pedal_aux) * 33'(AUX_MULT);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage.start_button <= i_start_button;
            r_stage.brake_level  <= i_brake_level;
            r_stage.pedal_main   <= i_pedal_main;
            r_stage.scaled_aux   <= aux_prod[AUX_SHIFT +: SCALED_W];
            r_stage.torque_word  <= tq_word;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/core/vspc_ctrl.sv
// Mode sequencer, timers and pedal plausibility check of the vehicle start unit.
// Depends on vspc_pkg for the mode codes, t_cfg, t_stage and t_result.
module vspc_ctrl import vspc_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_cfg    i_cfg,
    input  t_stage  i_stage,
    output t_result o_result
);

    localparam int CW = (TIMER_BITS > CFG_TIMER_W) ? TIMER_BITS : CFG_TIMER_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    logic [1:0]            r_mode,      n_mode;
    logic [TIMER_BITS-1:0] r_phase,     n_phase;
    logic                  r_mm_active, n_mm_active;
    logic [TIMER_BITS-1:0] r_mm_timer,  n_mm_timer;

    logic                  braked;
    logic [SCALED_W-1:0]   diff;
    logic [17:0]           diff_pct;
    logic [17:0]           tol_main;
    logic                  mism;
    logic [TIMER_BITS-1:0] phase_up;
    logic [TIMER_BITS-1:0] mm_up;
    logic                  buzzer;
    logic                  valid;

    function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] t);
        return (t == TMAX) ? t : t + 1'b1;
    endfunction

    function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                     input logic [CFG_TIMER_W-1:0] lim);
        return CW'(t) >= CW'(lim);
    endfunction

    // Brake compare and pedal plausibility
    assign braked   = i_stage.brake_level > i_cfg.brake_limit;
    assign diff     = (SCALED_W'(i_stage.pedal_main) >= i_stage.scaled_aux)
                    ? SCALED_W'(i_stage.pedal_main) - i_stage.scaled_aux
                    : i_stage.scaled_aux - SCALED_W'(i_stage.pedal_main);
    assign diff_pct = 18'(diff) * 18'd100;
    assign tol_main = 18'(i_cfg.tolerance_percent) * 18'(i_stage.pedal_main);
    assign mism     = diff_pct > tol_main;
    assign phase_up = tick_up(r_phase);
    assign mm_up    = tick_up(r_mm_timer);

    // Next state
    always_comb begin
        n_mode      = r_mode;
        n_phase     = r_phase;
        n_mm_active = r_mm_active;
        n_mm_timer  = r_mm_timer;
        buzzer      = 1'b0;
        valid       = 1'b0;
        unique case (r_mode)
            MODE_IDLE: begin
                if (i_stage.start_button && braked) begin
                    n_mode  = MODE_SHOLD;
                    n_phase = '0;
                end
            end
            MODE_SHOLD: begin
                if (!braked || !i_stage.start_button) begin
                    n_mode = MODE_IDLE;
                end else if (reached(phase_up, i_cfg.start_hold_ticks)) begin
                    n_mode  = MODE_BUZZER;
                    n_phase = '0;
                end else begin
                    n_phase = phase_up;
                end
            end
            MODE_BUZZER: begin
                n_phase = phase_up;
                if (reached(phase_up, i_cfg.buzzer_ticks)) begin
                    n_mode = MODE_DRIVE;
                end else begin
                    buzzer = 1'b1;
                end
            end
            MODE_DRIVE: begin
                valid = 1'b1;
                if (mism) begin
                    if (r_mm_active) begin
                        n_mm_timer = mm_up;
                        if (reached(mm_up, i_cfg.mismatch_ticks)) begin
                            n_mode      = MODE_IDLE;
                            n_mm_active = 1'b0;
                            valid       = 1'b0;
                        end
                    end else begin
                        n_mm_active = 1'b1;
                        n_mm_timer  = '0;
                    end
                end else begin
                    n_mm_active = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_phase     <= '0;
            r_mm_active <= 1'b0;
            r_mm_timer  <= '0;
        end else if (i_en) begin
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_mm_active <= n_mm_active;
            r_mm_timer  <= n_mm_timer;
        end
    end

    // Result for this beat
    always_comb begin
        o_result.vehicle_state    = n_mode;
        o_result.brake_light      = braked;
        o_result.buzzer_on        = buzzer;
        o_result.torque_command   = valid ? $signed(i_stage.torque_word) : '0;
        o_result.torque_valid     = valid;
        o_result.mismatch_pending = n_mm_active;
    end

endmodule

FILE: rtl/core/vehicle_start_and_pedal_check_unit.sv
// Top level of the vehicle start and pedal check unit: stream ports, APB port, result register.
// Depends on vspc_pkg, vspc_regs, vspc_prep and vspc_ctrl.
//
// Use: each input beat on s_axis is one tick (start button, brake level and two
// accelerator readings). Every tick gives exactly one result beat on m_axis with
// the vehicle mode after the tick, brake light, buzzer, torque command and the
// pedal mismatch flag. Registers are to be written over the APB port only while
// the block is idle; the block itself does not enforce this. pready is always
// high and reads return the register value. A beat passes the input register,
// then the result register, before it reaches m_axis. Throughput: one beat per
// cycle unless the receiver stalls, set by the mode update between the registers.
// A stalled receiver holds the result register; the input register still takes
// one more beat, after which s_axis_tready drops until the result is taken.
// Reset (synchronous, active low) returns the mode to idle, clears the timers
// and mismatch flag, empties both registers and loads the register defaults.
module vehicle_start_and_pedal_check_unit import vspc_pkg::*; #(
    parameter int ADC_MAX    = 1023,
    parameter int TIMER_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] start_button, [10:1] brake_level, [20:11] pedal_main, [30:21] pedal_aux
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] vehicle_state, [2] brake_light, [3] buzzer_on, [19:4] torque_command,
    // [20] torque_valid, [21] mismatch_pending
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_cfg    cfg;
    t_stage  stage;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    r_in_valid;
    logic    in_beat;
    logic    advance;

    // Pipeline flow control
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    vspc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vspc_prep #(
        .ADC_MAX (ADC_MAX)
    ) u_prep (
        .i_clk          (i_clk),
        .i_load         (in_beat),
        .i_cfg          (cfg),
        .i_start_button (s_axis_tdata[0]),
        .i_brake_level  (s_axis_tdata[10:1]),
        .i_pedal_main   (s_axis_tdata[20:11]),
        .i_pedal_aux    (s_axis_tdata[30:21]),
        .o_stage        (stage)
    );

    vspc_ctrl #(
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (cfg),
        .i_stage  (stage),
        .o_result (result)
    );

    // Valid flags of the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.mismatch_pending, r_out.torque_valid,
                            r_out.torque_command, r_out.buzzer_on, r_out.brake_light,
                            r_out.vehicle_state};

    // Torque is only issued from a drive tick
    a_torque_in_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.torque_valid |-> r_out.vehicle_state == MODE_DRIVE)
        else $error("torque issued outside drive");

    // Buzzer sounds only while the mode is buzzer
    a_buzzer_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.buzzer_on |-> r_out.vehicle_state == MODE_BUZZER)
        else $error("buzzer on outside buzzer mode");

    // Torque is zero when not valid
    a_torque_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.torque_valid |-> r_out.torque_command == '0)
        else $error("nonzero torque without valid");

    // Input side stalls only because a full result register is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for vehicle_start_and_pedal_check_unit.
// Needs vspc_pkg and the unit's RTL; an in-bench predictor of the start sequence and
// pedal plausibility check sets the expected result beat for each accepted tick.
module testbench;
    import vspc_pkg::*;

    localparam int ADC_FULL  = 1023;
    localparam int STALL_LEN = 150;

    typedef struct packed {
        logic [1:0]         vstate;
        logic               brake_light;
        logic               buzzer_on;
        logic signed [15:0] torque;
        logic               torque_valid;
        logic               mismatch_pending;
    } t_tick_out;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    // [0] start_button, [10:1] brake_level, [20:11] pedal_main, [30:21] pedal_aux
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [1:0] vehicle_state, [2] brake_light, [3] buzzer_on, [19:4] torque_command,
    // [20] torque_valid, [21] mismatch_pending
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [4:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    wire [31:0]             prdata;
    wire                    pready;

    // Predictor copy of registers and state, at their reset values
    logic [9:0]  cfg_brake_thr = 10'd200;
    logic [15:0] cfg_hold = 16'd2000;
    logic [15:0] cfg_buzz = 16'd2000;
    logic [15:0] cfg_mis = 16'd100;
    logic        cfg_fwd = 1'b1;
    logic [6:0]  cfg_tol = 7'd10;
    logic [1:0]  veh_mode = MODE_IDLE;
    logic [15:0] phase_ticks = '0;
    logic        mis_active = 1'b0;
    logic [15:0] mis_ticks = '0;

    t_tick_out expected_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stall_served = 0;
    int stall_left = 0;
    int drive_budget = 0;
    int ticks_sent = 0;
    int torque_ticks = 0;
    int mismatch_exits = 0;
    int reg_writes = 0;
    int errors = 0;

    vehicle_start_and_pedal_check_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("vehicle_start_and_pedal_check_unit: mismatch");
        $finish;
    end

    function automatic logic [15:0] sat_inc(input logic [15:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

    // Advance the predictor by one tick and return the expected result beat
    function automatic t_tick_out vehicle_step(input logic start, input logic [9:0] brake,
                                               input logic [9:0] pmain,
                                               input logic [9:0] paux);
        t_tick_out r;
        logic braked;
        logic mism;
        logic leave;
        int scaled;
        int diff;
        int trq;
        r = '0;
        braked = brake > cfg_brake_thr;
        leave = 1'b0;
        case (veh_mode)
            MODE_IDLE: begin
                if (start && braked) begin
                    veh_mode = MODE_SHOLD;
                    phase_ticks = '0;
                end
            end
            MODE_SHOLD: begin
                if (!braked || !start) begin
                    veh_mode = MODE_IDLE;
                end else begin
                    phase_ticks = sat_inc(phase_ticks);
                    if (phase_ticks >= cfg_hold) begin
                        veh_mode = MODE_BUZZER;
                        phase_ticks = '0;
                    end
                end
            end
            MODE_BUZZER: begin
                phase_ticks = sat_inc(phase_ticks);
                if (phase_ticks >= cfg_buzz) veh_mode = MODE_DRIVE;
                else r.buzzer_on = 1'b1;
            end
            default: begin
                // aux sensor runs off 3.3 V: scale up by 50/33 before comparing
                scaled = int'(paux) * 50 / 33;
                diff = (int'(pmain) >= scaled) ? int'(pmain) - scaled : scaled - int'(pmain);
                mism = diff * 100 > int'(cfg_tol) * int'(pmain);
                if (mism) begin
                    if (mis_active) begin
                        mis_ticks = sat_inc(mis_ticks);
                        if (mis_ticks >= cfg_mis) begin
                            veh_mode = MODE_IDLE;
                            mis_active = 1'b0;
                            leave = 1'b1;
                            mismatch_exits++;
                        end
                    end else begin
                        mis_active = 1'b1;
                        mis_ticks = '0;
                    end
                end else begin
                    mis_active = 1'b0;
                end
                if (!leave) begin
                    if (cfg_fwd) trq = int'(pmain) * 32767 / ADC_FULL;
                    else trq = -(int'(pmain) * 32768 / ADC_FULL);
                    r.torque = trq[15:0];
                    r.torque_valid = 1'b1;
                    torque_ticks++;
                end
            end
        endcase
        r.vstate = veh_mode;
        r.brake_light = braked;
        r.mismatch_pending = mis_active;
        return r;
    endfunction

    // Offer one tick, wait for the beat to be taken, then log its expected result
    task automatic send_tick(input logic start, input logic [9:0] brake,
                             input logic [9:0] pmain, input logic [9:0] paux);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, paux, pmain, brake, start};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(vehicle_step(start, brake, pmain, paux));
        ticks_sent++;
    endtask

    // Stop sending and wait for every outstanding result, plus pipeline slack
    task automatic drain_results();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup then access; the predictor takes the masked value
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BRAKE_THR:  cfg_brake_thr = value[9:0];
            REG_START_HOLD: cfg_hold = value[15:0];
            REG_BUZZER:     cfg_buzz = value[15:0];
            REG_MISMATCH:   cfg_mis = value[15:0];
            REG_FORWARD:    cfg_fwd = value[0];
            REG_TOLERANCE:  cfg_tol = value[6:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_all(input int thr, input int hold, input int buzz, input int mis,
                             input int fwd, input int tol);
        write_reg(REG_BRAKE_THR, thr);
        write_reg(REG_START_HOLD, hold);
        write_reg(REG_BUZZER, buzz);
        write_reg(REG_MISMATCH, mis);
        write_reg(REG_FORWARD, fwd);
        write_reg(REG_TOLERANCE, tol);
    endtask

    // Random field value, sometimes with garbage above the register width
    function automatic int with_junk(input int value, input int width);
        return ($urandom_range(3) == 0) ? (value | ($urandom << width)) : value;
    endfunction

    // Mostly short timers so the sequence reaches drive; extremes now and then
    task automatic random_settings();
        int thr;
        int hold;
        int buzz;
        int mis;
        thr = ($urandom_range(9) == 0) ? 1023 : $urandom_range(0, 1000);
        hold = ($urandom_range(15) == 0) ? 65535 : $urandom_range(0, 6);
        buzz = ($urandom_range(15) == 0) ? 65535 : $urandom_range(0, 6);
        mis = ($urandom_range(15) == 0) ? 65535 : $urandom_range(0, 8);
        write_all(with_junk(thr, 10), with_junk(hold, 16), with_junk(buzz, 16),
                  with_junk(mis, 16), with_junk($urandom_range(1), 1),
                  with_junk($urandom_range(127), 7));
    endtask

    // One tick shaped by the predicted mode: hold start and brake to climb the
    // sequence, keep the pedals agreeing in drive, then force a mismatch exit
    task automatic random_tick();
        logic       start;
        logic [9:0] brake;
        logic [9:0] pmain;
        logic [9:0] paux;
        int pick;
        int aux;
        pick = $urandom_range(99);
        start = 1'($urandom);
        brake = 10'($urandom);
        pmain = 10'($urandom);
        paux = 10'($urandom);
        if (veh_mode != MODE_DRIVE) drive_budget = $urandom_range(4, 30);
        case (veh_mode)
            MODE_IDLE, MODE_SHOLD: begin
                if (pick < ((veh_mode == MODE_IDLE) ? 70 : 93) && cfg_brake_thr != 10'h3FF) begin
                    start = 1'b1;
                    brake = 10'($urandom_range(int'(cfg_brake_thr) + 1, 1023));
                end
            end
            MODE_DRIVE: begin
                if (drive_budget > 0 && pick < 70) begin
                    aux = int'(pmain) * 33 / 50 + $urandom_range(2) - 1;
                    paux = (aux < 0) ? 10'd0 : aux[9:0];
                end else if (drive_budget == 0 || pick < 88) begin
                    pmain = 10'($urandom_range(0, 300));
                    paux = 10'($urandom_range(900, 1023));
                end
                if (drive_budget > 0) drive_budget--;
            end
            default: ;
        endcase
        send_tick(start, brake, pmain, paux);
    endtask

    // Brake threshold edge, start-hold entry and both ways back to idle, default registers
    task automatic test_start_hold_defaults();
        send_tick(1'b0, 10'd0, 10'd0, 10'd0);
        send_tick(1'b1, 10'd0, 10'd1023, 10'd1023);
        send_tick(1'b0, 10'd1023, 10'd0, 10'd0);
        send_tick(1'b1, 10'd200, 10'd512, 10'd337);
        send_tick(1'b1, 10'd201, 10'd1023, 10'd0);
        send_tick(1'b1, 10'd1023, 10'd0, 10'd1023);
        send_tick(1'b0, 10'd1023, 10'd300, 10'd200);
        send_tick(1'b1, 10'd201, 10'd5, 10'd5);
        send_tick(1'b1, 10'd200, 10'd5, 10'd5);
        drain_results();
    endtask

    // Zero and one tick timers, zero main reading, tight and loose tolerance, reverse
    task automatic test_short_timers();
        write_all(0, 0, 0, 0, 0, 0);
        send_tick(1'b1, 10'd1, 10'd0, 10'd0);
        send_tick(1'b1, 10'd1, 10'd0, 10'd0);
        send_tick(1'b0, 10'd0, 10'd0, 10'd0);
        send_tick(1'b0, 10'd0, 10'd1023, 10'd675);
        send_tick(1'b0, 10'd0, 10'd0, 10'd0);
        send_tick(1'b1, 10'd9, 10'd1023, 10'd1023);
        send_tick(1'b0, 10'd0, 10'd0, 10'd1);
        drain_results();
        write_all(0, 1, 1, 3, 1, 127);
        send_tick(1'b1, 10'd1, 10'd0, 10'd0);
        send_tick(1'b1, 10'd1, 10'd0, 10'd0);
        send_tick(1'b0, 10'd0, 10'd0, 10'd0);
        send_tick(1'b0, 10'd0, 10'd1023, 10'd675);
        send_tick(1'b1, 10'd1023, 10'd512, 10'd0);
        send_tick(1'b0, 10'd0, 10'd100, 10'd1023);
        drain_results();
    endtask

    // Random ticks over several register settings; the first may be the upper limits
    task automatic run_random(input int snd_pct, input int rcv_pct, input bit limits_first);
        int sent0;
        int n;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        sent0 = ticks_sent;
        while (ticks_sent - sent0 < 330) begin
            drain_results();
            if (limits_first) write_all(1023, 65535, 65535, 65535, 1, 127);
            else random_settings();
            limits_first = 1'b0;
            n = $urandom_range(30, 70);
            repeat (n) random_tick();
        end
        drain_results();
    endtask

    // Receiver holds off for a long stretch while ticks keep coming
    task automatic test_receiver_holdoff();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(100, 2, 2, 4, 0, 20);
        stall_requests++;
        repeat (40) random_tick();
        drain_results();
    endtask

    task automatic test_slow_receiver();
        run_random(18, 46, 1'b1);
    endtask

    task automatic test_slow_sender();
        run_random(46, 18, 1'b0);
    endtask

    task automatic test_full_rate();
        run_random(0, 0, 1'b0);
    endtask

    // Result side ready, with random gaps and requested long hold-offs
    always @(posedge i_clk) begin
        if (stall_served != stall_requests) begin
            stall_served++;
            stall_left = STALL_LEN;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_tick_out exp_out;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no tick outstanding: %h", m_axis_tdata);
                errors++;
            end else begin
                exp_out = expected_results.pop_front();
                report_field("vehicle_state", exp_out.vstate, m_axis_tdata[1:0]);
                report_field("brake_light", exp_out.brake_light, m_axis_tdata[2]);
                report_field("buzzer_on", exp_out.buzzer_on, m_axis_tdata[3]);
                report_field("torque_command", exp_out.torque, $signed(m_axis_tdata[19:4]));
                report_field("torque_valid", exp_out.torque_valid, m_axis_tdata[20]);
                report_field("mismatch_pending", exp_out.mismatch_pending, m_axis_tdata[21]);
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_start_hold_defaults();
        test_short_timers();
        test_slow_receiver();
        test_receiver_holdoff();
        test_slow_sender();
        test_full_rate();
        drain_results();
        $display("Run covered %0d ticks over %0d register writes: %0d drive ticks with torque,",
                 ticks_sent, reg_writes, torque_ticks);
        $display("%0d pedal mismatch exits to idle, with stalls and gaps on both stream sides.",
                 mismatch_exits);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("vehicle_start_and_pedal_check_unit: match");
        end else begin
            if (expected_results.size() != 0)
                $error("%0d result beats never arrived", expected_results.size());
            $display("vehicle_start_and_pedal_check_unit: mismatch");
        end
        $finish;
    end

endmodule
